### rtl/core/mstk_pkg.sv
package mstk_pkg;

    localparam int EDGE_CAPACITY_DEF = 256;
    localparam int VERTEX_COUNT_DEF  = 64;
    localparam int WEIGHT_BITS_DEF   = 16;

    localparam int VTX_W   = 6;
    localparam int WGT_W   = 16;
    localparam int COST_W  = 22;
    localparam int MAX_EDGE_RESULTS = 63;

    localparam logic signed [COST_W-1:0] COST_MAX = 22'sh1FFFFF;
    localparam logic signed [COST_W-1:0] COST_MIN = -22'sh200000;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_SHIFT,
        ST_SORT_PUT,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN_ORD,
        ST_FIND_A,
        ST_FIND_B,
        ST_JOIN,
        ST_EMIT,
        ST_TOTAL,
        ST_WAIT
    } mstk_state_t;

    // shared weight comparator request
    typedef struct packed {
        logic signed [WGT_W-1:0] lhs;
        logic signed [WGT_W-1:0] rhs;
    } mstk_cmp_t;

endpackage

### rtl/core/minimum_spanning_tree_kruskal_core.sv
// Kruskal minimum spanning tree core.
// Input channel (in_valid/in_ready): one edge per item: edge_source, edge_target,
// edge_weight, last_edge. Edges load one per cycle into the edge memory.
// The item with last_edge set starts the run; edges beyond capacity are dropped.
// During the run in_ready is low. The run is a stable insertion sort of an index
// memory (each order entry is compared through a single shared weight
// comparator and shifted up while its edge is heavier), a parent table clear,
// then a scan of the sorted edges with a root search per endpoint that
// follows parent links; an edge with an endpoint out of range is skipped.
// Output channel (out_valid/out_ready): one item per tree edge with the
// saturating running cost, then one total item with is_total set. The sequencer
// holds in the emit state while the receiver stalls; nothing is lost.
// Reset clears the count and control state; the parent table is cleared by the
// sweep before the scan of every run, so no clearing pass is needed after reset.
module minimum_spanning_tree_kruskal_core
    import mstk_pkg::*;
#(
    parameter int EDGE_CAPACITY = EDGE_CAPACITY_DEF,
    parameter int VERTEX_COUNT  = VERTEX_COUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [VTX_W-1:0]         edge_source,
    input  logic [VTX_W-1:0]         edge_target,
    input  logic signed [WGT_W-1:0]  edge_weight,
    input  logic                     last_edge,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [VTX_W-1:0]         tree_source,
    output logic [VTX_W-1:0]         tree_target,
    output logic signed [WGT_W-1:0]  tree_weight,
    output logic signed [COST_W-1:0] running_cost,
    output logic                     is_total
);
    localparam int AW  = $clog2(EDGE_CAPACITY);
    localparam int CW  = $clog2(EDGE_CAPACITY + 1);
    localparam int VW  = $clog2(VERTEX_COUNT);
    localparam int PW  = $clog2(VERTEX_COUNT + 1);
    localparam int EW  = 2 * VTX_W + WGT_W;
    localparam logic [PW-1:0] ROOT_MARK = PW'(VERTEX_COUNT);

    // memories
    logic [EW-1:0] edge_mem [EDGE_CAPACITY];
    logic [AW-1:0] ord_mem  [EDGE_CAPACITY];
    logic [PW-1:0] par_mem  [VERTEX_COUNT];

    mstk_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] hop_reg, hop_next;
    logic [PW-1:0] v_reg, v_next;
    logic [PW-1:0] ra_reg, ra_next;
    logic [5:0]    prod_reg, prod_next;
    logic signed [WGT_W-1:0]  cur_w_reg, cur_w_next;
    logic signed [COST_W-1:0] cost_reg, cost_next;

    // registered memory read data
    logic [EW-1:0] edge_rd_reg;
    logic [AW-1:0] ord_rd_reg;
    logic [PW-1:0] par_rd_reg;

    // memory control
    logic          edge_we;
    logic [AW-1:0] edge_wa, edge_ra;
    logic          ord_we;
    logic [AW-1:0] ord_wa, ord_ra;
    logic [AW-1:0] ord_wd;
    logic          par_we;
    logic [VW-1:0] par_wa, par_ra;
    logic [PW-1:0] par_wd;

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_wa] <= {edge_source, edge_target, edge_weight};
        edge_rd_reg <= edge_mem[edge_ra];
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
        ord_rd_reg <= ord_mem[ord_ra];
        if (par_we)
            par_mem[par_wa] <= par_wd;
        par_rd_reg <= par_mem[par_ra];
    end

    logic [VTX_W-1:0]        e_src, e_dst;
    logic signed [WGT_W-1:0] e_wgt;
    assign e_src = edge_rd_reg[EW-1 -: VTX_W];
    assign e_dst = edge_rd_reg[WGT_W +: VTX_W];
    assign e_wgt = edge_rd_reg[WGT_W-1:0];

    mstk_cmp_t cmp_req;
    logic      cmp_gt;
    mstk_cmp u_cmp (.req(cmp_req), .greater(cmp_gt));

    logic signed [COST_W-1:0] sum;
    mstk_sat_add u_add (.acc(cost_reg), .addend(e_wgt), .sum(sum));

    logic src_ok, dst_ok;
    assign src_ok = {1'b0, e_src} < (VTX_W+1)'(VERTEX_COUNT);
    assign dst_ok = {1'b0, e_dst} < (VTX_W+1)'(VERTEX_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            hop_reg   <= '0;
            v_reg     <= '0;
            ra_reg    <= '0;
            prod_reg  <= '0;
            cur_w_reg <= '0;
            cost_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            hop_reg   <= hop_next;
            v_reg     <= v_next;
            ra_reg    <= ra_next;
            prod_reg  <= prod_next;
            cur_w_reg <= cur_w_next;
            cost_reg  <= cost_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        hop_next   = hop_reg;
        v_next     = v_reg;
        ra_next    = ra_reg;
        prod_next  = prod_reg;
        cur_w_next = cur_w_reg;
        cost_next  = cost_reg;
        edge_we = 1'b0;
        edge_wa = count_reg[AW-1:0];
        // by default the scan's order entry and edge stay in the read registers
        edge_ra = ord_rd_reg;
        ord_we  = 1'b0;
        ord_wa  = '0;
        ord_wd  = '0;
        ord_ra  = i_reg[AW-1:0];
        par_we  = 1'b0;
        par_wa  = '0;
        par_wd  = ROOT_MARK;
        par_ra  = '0;
        cmp_req.lhs = e_wgt;
        cmp_req.rhs = cur_w_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        tree_source  = '0;
        tree_target  = '0;
        tree_weight  = '0;
        running_cost = cost_reg;
        is_total     = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (count_reg < CW'(EDGE_CAPACITY))
                    begin
                        edge_we    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (last_edge)
                    begin
                        i_next     = '0;
                        state_next = ST_SORT_RD;
                    end
                end
            end
            // insertion of edge i: read its weight
            ST_SORT_RD:
            begin
                if (i_reg == count_reg)
                begin
                    v_next     = '0;
                    state_next = ST_CLEAR;
                end
                else
                begin
                    edge_ra    = i_reg[AW-1:0];
                    ord_ra     = AW'(i_reg - 1'b1);
                    j_next     = i_reg;
                    hop_next   = '0;
                    state_next = ST_SORT_CMP;
                end
            end
            // ord_rd_reg holds order[j-1]; fetch its edge for the compare.
            // On the first pass edge_rd_reg holds edge i.
            ST_SORT_CMP:
            begin
                if (hop_reg == '0)
                begin
                    cur_w_next = e_wgt;
                    hop_next   = CW'(1);
                    if (j_reg == '0)
                        state_next = ST_SORT_PUT;
                    else
                    begin
                        edge_ra    = ord_rd_reg;
                        ord_ra     = AW'(j_reg - 1'b1);
                        state_next = ST_SORT_SHIFT;
                    end
                end
                else
                begin
                    edge_ra    = ord_rd_reg;
                    ord_ra     = AW'(j_reg - 1'b1);
                    state_next = ST_SORT_SHIFT;
                end
            end
            ST_SORT_SHIFT:
            begin
                // edge_rd_reg = edge of order[j-1], ord_rd_reg = order[j-1]
                if (cmp_gt)
                begin
                    ord_we = 1'b1;
                    ord_wa = j_reg[AW-1:0];
                    ord_wd = ord_rd_reg;
                    j_next = j_reg - 1'b1;
                    if (j_reg == CW'(1))
                        state_next = ST_SORT_PUT;
                    else
                    begin
                        ord_ra     = AW'(j_reg - CW'(2));
                        state_next = ST_SORT_CMP;
                    end
                end
                else
                    state_next = ST_SORT_PUT;
                if (state_next == ST_SORT_CMP)
                    hop_next = CW'(2);
            end
            ST_SORT_PUT:
            begin
                ord_we     = 1'b1;
                ord_wa     = j_reg[AW-1:0];
                ord_wd     = i_reg[AW-1:0];
                hop_next   = '0;
                i_next     = i_reg + 1'b1;
                state_next = ST_SORT_RD;
            end
            ST_CLEAR:
            begin
                par_we = 1'b1;
                par_wa = v_reg[VW-1:0];
                par_wd = ROOT_MARK;
                v_next = v_reg + 1'b1;
                if (v_reg == PW'(VERTEX_COUNT - 1))
                begin
                    i_next     = '0;
                    prod_next  = '0;
                    cost_next  = '0;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (i_reg == count_reg)
                    state_next = ST_TOTAL;
                else
                begin
                    ord_ra     = i_reg[AW-1:0];
                    state_next = ST_SCAN_ORD;
                end
            end
            ST_SCAN_ORD:
            begin
                edge_ra    = ord_rd_reg;
                hop_next   = '0;
                state_next = ST_FIND_A;
                v_next     = '0;
                ra_next    = ROOT_MARK;
            end
            // root walk: v_reg holds current vertex, par_rd_reg its link
            ST_FIND_A, ST_FIND_B:
            begin
                if (hop_reg == '0)
                begin
                    if (!src_ok || !dst_ok)
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_SCAN_RD;
                    end
                    else
                    begin
                        v_next   = PW'(state_reg == ST_FIND_A ? e_src : e_dst);
                        par_ra   = VW'(state_reg == ST_FIND_A ? e_src : e_dst);
                        hop_next = CW'(1);
                    end
                end
                else if (par_rd_reg < ROOT_MARK && hop_reg <= CW'(VERTEX_COUNT))
                begin
                    v_next   = par_rd_reg;
                    par_ra   = par_rd_reg[VW-1:0];
                    hop_next = hop_reg + 1'b1;
                end
                else if (state_reg == ST_FIND_A)
                begin
                    ra_next    = v_reg;
                    hop_next   = '0;
                    state_next = ST_FIND_B;
                end
                else
                    state_next = ST_JOIN;
            end
            ST_JOIN:
            begin
                if (ra_reg == v_reg || prod_reg >= 6'(MAX_EDGE_RESULTS))
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    par_we     = 1'b1;
                    par_wa     = ra_reg[VW-1:0];
                    par_wd     = v_reg;
                    cost_next  = sum;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid   = 1'b1;
                tree_source = e_src;
                tree_target = e_dst;
                tree_weight = e_wgt;
                if (out_ready)
                begin
                    prod_next  = prod_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_TOTAL:
            begin
                out_valid = 1'b1;
                is_total  = 1'b1;
                if (out_ready)
                begin
                    count_next = '0;
                    state_next = ST_LOAD;
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    ast_no_in_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_LOAD |-> !in_ready)
        else $error("input taken during run");
    ast_total_resets_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TOTAL && out_ready) |=> count_reg == '0)
        else $error("count not cleared after total");
    ast_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_EMIT || state_reg == ST_TOTAL))
        else $error("output outside emit");
    ast_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(EDGE_CAPACITY))
        else $error("edge count overflow");
endmodule

### rtl/core/mstk_cmp.sv
module mstk_cmp
    import mstk_pkg::*;
(
    input  mstk_cmp_t req,
    output logic      greater
);
    assign greater = req.lhs > req.rhs;
endmodule

### rtl/core/mstk_sat_add.sv
module mstk_sat_add
    import mstk_pkg::*;
(
    input  logic signed [COST_W-1:0] acc,
    input  logic signed [WGT_W-1:0]  addend,
    output logic signed [COST_W-1:0] sum
);
    logic signed [COST_W:0] wide;
    always_comb
    begin
        wide = {acc[COST_W-1], acc} + {{(COST_W+1-WGT_W){addend[WGT_W-1]}}, addend};
        if (wide > $signed({COST_MAX[COST_W-1], COST_MAX}))
            sum = COST_MAX;
        else if (wide < $signed({COST_MIN[COST_W-1], COST_MIN}))
            sum = COST_MIN;
        else
            sum = wide[COST_W-1:0];
    end
endmodule
